>>> sv/spimfe_pkg.sv
// Shared types and constants for the SPI master frame exchange block.
`timescale 1ns / 1ps

package spimfe_pkg;

  localparam int WORD_W = 16;
  localparam int BIT_W  = 5;
  localparam int POS_W  = 4;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_FRAME_BITS   = 3'd0;
  localparam logic [2:0] REG_CAPTURE_1ST  = 3'd1;
  localparam logic [2:0] REG_MSB_FIRST    = 3'd2;
  localparam logic [2:0] REG_CLK_IDLE_LOW = 3'd3;
  localparam logic [2:0] REG_RX_ENABLE    = 3'd4;
  localparam logic [2:0] REG_TX_ENABLE    = 3'd5;

  localparam logic [BIT_W-1:0] FRAME_BITS_RST = 5'd8;

  // Command codes of an input word.
  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // One classified command waiting for the back end.
  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] tx_word;
    logic              miso_level;
  } q_item_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [BIT_W-1:0] frame_bits;
    logic             capture_first_edge;
    logic             msb_first;
    logic             clock_idle_low;
    logic             receive_enable;
    logic             transmit_enable;
  } cfg_t;

endpackage

>>> sv/spimfe_if.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps

interface spimfe_in_if import spimfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [WORD_W-1:0] tx_word;
  logic              miso_level;

  modport source (output valid, cmd, tx_word, miso_level, input ready);
  modport sink (input valid, cmd, tx_word, miso_level, output ready);
endinterface

interface spimfe_out_if import spimfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              sck_level;
  logic              mosi_level;
  logic              cs_n_level;
  logic [WORD_W-1:0] rx_word;
  logic              done_res;
  logic              busy_res;

  modport source (output valid, sck_level, mosi_level, cs_n_level, rx_word, done_res,
                  busy_res, input ready);
  modport sink (input valid, sck_level, mosi_level, cs_n_level, rx_word, done_res,
                busy_res, output ready);
endinterface

>>> sv/spimfe_cfg.sv
// APB-style configuration registers with frame size saturation.
`timescale 1ns / 1ps

module spimfe_cfg import spimfe_pkg::*; #(
  parameter int MAX_FRAME_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam int FRAME_HI = (MAX_FRAME_BITS < WORD_W) ? MAX_FRAME_BITS : WORD_W;
  localparam logic [BIT_W-1:0] FRAME_HI_V = BIT_W'(FRAME_HI);

  cfg_t             cfg_r;
  logic [2:0]       idx;
  logic             wr_en;
  logic [BIT_W-1:0] fb_raw;
  logic [BIT_W-1:0] fb_sat;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  assign fb_raw = pwdata[BIT_W-1:0];

  always_comb begin
    if (fb_raw == '0) begin
      fb_sat = BIT_W'(1);
    end else if (fb_raw > FRAME_HI_V) begin
      fb_sat = FRAME_HI_V;
    end else begin
      fb_sat = fb_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_bits         <= FRAME_BITS_RST;
      cfg_r.capture_first_edge <= 1'b1;
      cfg_r.msb_first          <= 1'b1;
      cfg_r.clock_idle_low     <= 1'b1;
      cfg_r.receive_enable     <= 1'b1;
      cfg_r.transmit_enable    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_BITS:   cfg_r.frame_bits         <= fb_sat;
        REG_CAPTURE_1ST:  cfg_r.capture_first_edge <= pwdata[0];
        REG_MSB_FIRST:    cfg_r.msb_first          <= pwdata[0];
        REG_CLK_IDLE_LOW: cfg_r.clock_idle_low     <= pwdata[0];
        REG_RX_ENABLE:    cfg_r.receive_enable     <= pwdata[0];
        REG_TX_ENABLE:    cfg_r.transmit_enable    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_BITS:   prdata = {27'd0, cfg_r.frame_bits};
      REG_CAPTURE_1ST:  prdata = {31'd0, cfg_r.capture_first_edge};
      REG_MSB_FIRST:    prdata = {31'd0, cfg_r.msb_first};
      REG_CLK_IDLE_LOW: prdata = {31'd0, cfg_r.clock_idle_low};
      REG_RX_ENABLE:    prdata = {31'd0, cfg_r.receive_enable};
      REG_TX_ENABLE:    prdata = {31'd0, cfg_r.transmit_enable};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/spimfe_front.sv
// Front end: accepts command words, classifies them and queues them.
`timescale 1ns / 1ps

module spimfe_front import spimfe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  spimfe_in_if.sink     in_ch,
  output logic          q_valid,
  output q_item_t       q_item,
  input  logic          q_pop
);

  localparam int DEPTH = 2;

  q_item_t    q_mem_r [DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  q_item_t    item_in;

  assign in_ch.ready = (count_r != 2'(DEPTH));
  assign push        = in_ch.valid & in_ch.ready;

  // Classify the command bit into an operation code.
  always_comb begin
    item_in.op         = in_ch.cmd ? OP_TICK : OP_START;
    item_in.tx_word    = in_ch.tx_word;
    item_in.miso_level = in_ch.miso_level;
  end

  assign q_valid = (count_r != 2'd0);
  assign q_item  = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> sv/spimfe_back.sv
// Back end: runs the frame state machine and holds the result register.
`timescale 1ns / 1ps

module spimfe_back import spimfe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  q_item_t       q_item,
  output logic          q_pop,
  spimfe_out_if.source  out_ch
);

  typedef enum logic {
    ST_IDLE,
    ST_FRAME
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] tx_r, tx_nxt;
  logic [WORD_W-1:0] rx_r, rx_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              phase_r, phase_nxt;
  logic              sck_r, sck_nxt;
  logic              mosi_r, mosi_nxt;
  logic              out_valid_r;

  logic              sck_r_o, mosi_r_o, cs_r_o, done_r_o, busy_r_o;
  logic [WORD_W-1:0] rx_word_r;

  logic              idle_sck;
  logic [BIT_W-1:0]  bits_left;
  logic [POS_W-1:0]  pos;
  logic              done;
  logic [WORD_W-1:0] rx_out;

  assign q_pop    = q_valid & (~out_valid_r | out_ch.ready);
  assign idle_sck = ~cfg.clock_idle_low;

  // Bit position of the current edge, from the chosen bit order.
  assign bits_left = cfg.frame_bits - BIT_W'(1) - bit_r;
  assign pos       = cfg.msb_first ? bits_left[POS_W-1:0] : bit_r[POS_W-1:0];

  always_comb begin
    state_nxt = state_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    sck_nxt   = sck_r;
    mosi_nxt  = mosi_r;
    done      = 1'b0;
    rx_out    = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_item.op == OP_START) begin
          tx_nxt    = q_item.tx_word;
          rx_nxt    = '0;
          bit_nxt   = '0;
          phase_nxt = 1'b0;
          sck_nxt   = idle_sck ^ ~cfg.capture_first_edge;
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (q_item.op == OP_TICK) begin
          if (phase_r) begin
            sck_nxt   = ~sck_r;
            phase_nxt = 1'b0;
          end else if (bit_r < cfg.frame_bits) begin
            mosi_nxt    = cfg.transmit_enable & tx_r[pos];
            sck_nxt     = ~sck_r;
            rx_nxt[pos] = rx_r[pos] | (cfg.receive_enable & q_item.miso_level);
            bit_nxt     = bit_r + BIT_W'(1);
            phase_nxt   = cfg.capture_first_edge | (bit_nxt < cfg.frame_bits);
          end else begin
            state_nxt = ST_IDLE;
            done      = 1'b1;
            rx_out    = rx_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tx_r        <= '0;
      rx_r        <= '0;
      bit_r       <= '0;
      phase_r     <= 1'b0;
      sck_r       <= 1'b0;
      mosi_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        state_r   <= state_nxt;
        tx_r      <= tx_nxt;
        rx_r      <= rx_nxt;
        bit_r     <= bit_nxt;
        phase_r   <= phase_nxt;
        sck_r     <= sck_nxt;
        mosi_r    <= mosi_nxt;
        // Out of a frame the clock always sits at the idle level.
        sck_r_o   <= (state_nxt == ST_FRAME) ? sck_nxt : idle_sck;
        mosi_r_o  <= mosi_nxt;
        cs_r_o    <= (state_nxt != ST_FRAME);
        rx_word_r <= rx_out;
        done_r_o  <= done;
        busy_r_o  <= (state_nxt == ST_FRAME);
      end
      out_valid_r <= q_pop | (out_valid_r & ~out_ch.ready);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sck_level  = sck_r_o;
  assign out_ch.mosi_level = mosi_r_o;
  assign out_ch.cs_n_level = cs_r_o;
  assign out_ch.rx_word    = rx_word_r;
  assign out_ch.done_res   = done_r_o;
  assign out_ch.busy_res   = busy_r_o;

endmodule

>>> sv/spi_master_frame_exchange.sv
// Top level of the SPI master frame exchange block.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        cmd, tx_word, miso_level
//   out_ch    out        valid/ready        sck, mosi, cs_n, rx_word, done, busy
//   config    in         APB psel/penable   paddr, pwdata, prdata
//
// A steady stream runs at one word per clock while the result side takes every
// result; an accepted word passes through the two-entry command queue and then
// the result register.
// Reset is synchronous and active low; it clears the queue, the frame state and
// the configuration to its defaults (8-bit frames, MSB first, capture on the first
// edge, clock idle low, both directions enabled). No clearing pass is needed.
// A stall on the result side first fills the result register and then the queue;
// the input is refused only once both queue entries are occupied.
`timescale 1ns / 1ps

module spi_master_frame_exchange import spimfe_pkg::*; #(
  parameter int MAX_FRAME_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  spimfe_in_if.sink    in_ch,
  spimfe_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t    cfg;
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // Register file; a write lands on the access cycle of the APB transfer.
  spimfe_cfg #(
    .MAX_FRAME_BITS (MAX_FRAME_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The front end decodes each word into a start or a tick and queues it, so
  // it keeps accepting, until both entries are occupied, while the back end waits on a stalled result.
  spimfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // The back end advances the serial clock one edge per tick of a frame, save the tick that ends it, and registers the
  // pin levels and the received word as the result of every command.
  spimfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A frame end always deselects the slave and leaves the block idle.
  a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> out_ch.cs_n_level && !out_ch.busy_res)
    else $error("done result without chip select released");

  // Chip select is low exactly while a frame is in progress.
  a_cs_tracks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cs_n_level == !out_ch.busy_res))
    else $error("chip select disagrees with busy");

  // The received word is shown only on the word that ends a frame.
  a_rx_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.done_res |-> out_ch.rx_word == '0)
    else $error("received word outside a frame end");

  // The back end never takes a command from an empty queue.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
